@@ hdl/e2r_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_pkg: shared types and constants for the Euler-to-rotation-matrix block
// Fixed-point formats, axis and element indices, and the CORDIC arctangent
// table in 32-bit turn units.
// ----------------------------------------------------------------------------
package e2r_pkg;

    // Port field widths
    localparam int IN_W   = 16;
    localparam int ELEM_W = 16;

    // Lanes and matrix elements
    localparam int N_AXES = 3;
    localparam int N_ELEM = 9;

    // Angle in turn units (2^32 per turn)
    localparam int TURN_W = 32;

    // CORDIC datapath: x, y in Q30, residual angle in turn units
    localparam int XY_W     = 33;
    localparam int Z_W      = 33;
    localparam int CORDIC_Q = 30;
    localparam int ATAN_N   = 24;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

    // Sine and cosine in Q20
    localparam int TRIG_Q  = 20;
    localparam int TRIG_W  = 22;
    localparam int TRIG_SH = CORDIC_Q - TRIG_Q;
    localparam logic signed [XY_W-1:0] TRIG_RND = XY_W'(1) <<< (TRIG_SH - 1);

    // Products: pairs in Q40, sums in Q60
    localparam int PROD_W = 2 * TRIG_W;
    localparam int PL_W   = PROD_W + 1;
    localparam int PROD_Q = 2 * TRIG_Q;
    localparam int ACC_W  = 64;
    localparam int ACC_Q  = 3 * TRIG_Q;

    // Axis lanes
    localparam logic [1:0] AX_HEAD = 2'd0;
    localparam logic [1:0] AX_ATT  = 2'd1;
    localparam logic [1:0] AX_BANK = 2'd2;

    // Matrix element slots, row by row
    localparam logic [3:0] E_R0C0 = 4'd0;
    localparam logic [3:0] E_R0C1 = 4'd1;
    localparam logic [3:0] E_R0C2 = 4'd2;
    localparam logic [3:0] E_R1C0 = 4'd3;
    localparam logic [3:0] E_R1C1 = 4'd4;
    localparam logic [3:0] E_R1C2 = 4'd5;
    localparam logic [3:0] E_R2C0 = 4'd6;
    localparam logic [3:0] E_R2C1 = 4'd7;
    localparam logic [3:0] E_R2C2 = 4'd8;

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } t_trig;

    // Arctangent of 2^-i in turn units (2^32 per turn)
    function automatic logic signed [Z_W-1:0] atan_turn(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = Z_W'(536870912);
            5'd1:    v = Z_W'(316933406);
            5'd2:    v = Z_W'(167458907);
            5'd3:    v = Z_W'(85004756);
            5'd4:    v = Z_W'(42667331);
            5'd5:    v = Z_W'(21354465);
            5'd6:    v = Z_W'(10679838);
            5'd7:    v = Z_W'(5340245);
            5'd8:    v = Z_W'(2670163);
            5'd9:    v = Z_W'(1335087);
            5'd10:   v = Z_W'(667544);
            5'd11:   v = Z_W'(333772);
            5'd12:   v = Z_W'(166886);
            5'd13:   v = Z_W'(83443);
            5'd14:   v = Z_W'(41722);
            5'd15:   v = Z_W'(20861);
            5'd16:   v = Z_W'(10430);
            5'd17:   v = Z_W'(5215);
            5'd18:   v = Z_W'(2608);
            5'd19:   v = Z_W'(1304);
            5'd20:   v = Z_W'(652);
            5'd21:   v = Z_W'(326);
            5'd22:   v = Z_W'(163);
            5'd23:   v = Z_W'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/euler_to_rotation_matrix.sv @@
`timescale 1ns / 1ps
// Throughput: one beat per cycle while busy is low; the CORDIC stages and
// multiplier stages are fully pipelined, so busy is high only around reset.
// Reset: synchronous, active low; clears all valid bits, and busy is high
// while reset is held and in the cycle after. o_valid lasts one cycle.
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix: heading/attitude/bank to 3x3 rotation matrix
// CORDIC sine and cosine per angle, exact product pipeline, and rounding
// with saturation to signed Q1.FRAC_BITS.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix import e2r_pkg::*; #(
    parameter int ANGLE_BITS   = 16,
    parameter int FRAC_BITS    = 14,
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [IN_W-1:0]   i_heading,
    input  logic [IN_W-1:0]   i_attitude,
    input  logic [IN_W-1:0]   i_bank,
    output logic              o_valid,
    output logic [ELEM_W-1:0] o_elem_r0c0,
    output logic [ELEM_W-1:0] o_elem_r0c1,
    output logic [ELEM_W-1:0] o_elem_r0c2,
    output logic [ELEM_W-1:0] o_elem_r1c0,
    output logic [ELEM_W-1:0] o_elem_r1c1,
    output logic [ELEM_W-1:0] o_elem_r1c2,
    output logic [ELEM_W-1:0] o_elem_r2c0,
    output logic [ELEM_W-1:0] o_elem_r2c1,
    output logic [ELEM_W-1:0] o_elem_r2c2
);

    localparam int N_STEPS = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
    localparam int LATENCY = N_STEPS + 7;

    logic                          r_run;
    logic                          w_accept;
    logic [N_AXES-1:0][IN_W-1:0]   w_angle;
    logic                          w_trig_vld;
    t_trig                         w_trig [N_AXES];
    logic                          w_mat_vld;
    t_acc                          w_q60 [N_ELEM];
    logic [N_ELEM-1:0][ELEM_W-1:0] w_elem;

    // Hold off beats during reset and the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else begin
            r_run <= 1'b1;
        end
    end

    assign busy     = ~r_run | ~i_rst_n;
    assign w_accept = start & ~busy;

    always_comb begin
        w_angle[AX_HEAD] = i_heading;
        w_angle[AX_ATT]  = i_attitude;
        w_angle[AX_BANK] = i_bank;
    end

    e2r_sincos #(
        .ANGLE_BITS   (ANGLE_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_angle (w_angle),
        .o_valid (w_trig_vld),
        .o_trig  (w_trig)
    );

    e2r_mat u_mat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_trig_vld),
        .i_trig  (w_trig),
        .o_valid (w_mat_vld),
        .o_q60   (w_q60)
    );

    e2r_sat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mat_vld),
        .i_q60   (w_q60),
        .o_valid (o_valid),
        .o_elem  (w_elem)
    );

    assign o_elem_r0c0 = w_elem[E_R0C0];
    assign o_elem_r0c1 = w_elem[E_R0C1];
    assign o_elem_r0c2 = w_elem[E_R0C2];
    assign o_elem_r1c0 = w_elem[E_R1C0];
    assign o_elem_r1c1 = w_elem[E_R1C1];
    assign o_elem_r1c2 = w_elem[E_R1C2];
    assign o_elem_r2c0 = w_elem[E_R2C0];
    assign o_elem_r2c1 = w_elem[E_R2C1];
    assign o_elem_r2c2 = w_elem[E_R2C2];

endmodule

@@ hdl/e2r_sincos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_sincos: pipelined CORDIC sine and cosine for three angles
// One register stage folds the quadrant, one stage per CORDIC rotation,
// and one stage undoes the fold and rounds to Q20.
// ----------------------------------------------------------------------------
module e2r_sincos import e2r_pkg::*; #(
    parameter int ANGLE_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [N_AXES-1:0][IN_W-1:0]    i_angle,
    output logic                           o_valid,
    output t_trig                          o_trig [N_AXES]
);

    localparam int N_STEPS = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;
    localparam int ASH     = TURN_W - ANGLE_BITS;

    logic [TURN_W-1:0]       w_ext  [N_AXES];
    logic [TURN_W-1:0]       w_turn [N_AXES];
    logic                    w_flip [N_AXES];
    logic signed [Z_W-1:0]   w_z0   [N_AXES];

    logic signed [XY_W-1:0]  r_x    [N_STEPS+1][N_AXES];
    logic signed [XY_W-1:0]  r_y    [N_STEPS+1][N_AXES];
    logic signed [Z_W-1:0]   r_z    [N_STEPS+1][N_AXES];
    logic                    r_flip [N_STEPS+1][N_AXES];
    logic [N_STEPS:0]        r_vld;

    logic signed [XY_W-1:0]  w_xn   [N_AXES];
    logic signed [XY_W-1:0]  w_yn   [N_AXES];
    logic signed [XY_W-1:0]  w_cr   [N_AXES];
    logic signed [XY_W-1:0]  w_sr   [N_AXES];

    t_trig                   r_trig [N_AXES];
    logic                    r_out_vld;

    // Scale to turn units and fold angles in [pi/2, 3pi/2) by pi
    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            w_ext[a]  = {{(TURN_W-IN_W){i_angle[a][IN_W-1]}}, i_angle[a]};
            w_turn[a] = w_ext[a] << ASH;
            w_flip[a] = w_turn[a][TURN_W-1] ^ w_turn[a][TURN_W-2];
            w_z0[a]   = Z_W'($signed({w_turn[a][TURN_W-1] ^ w_flip[a],
                                      w_turn[a][TURN_W-2:0]}));
        end
    end

    // Load the first stage, then rotate once per stage with the direction
    // taken from the residual sign
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < N_AXES; a++) begin
            r_x[0][a]    <= CORDIC_GAIN;
            r_y[0][a]    <= '0;
            r_z[0][a]    <= w_z0[a];
            r_flip[0][a] <= w_flip[a];
        end
        for (int k = 0; k < N_STEPS; k++) begin
            for (int a = 0; a < N_AXES; a++) begin
                if (!r_z[k][a][Z_W-1]) begin
                    r_x[k+1][a] <= r_x[k][a] - (r_y[k][a] >>> k);
                    r_y[k+1][a] <= r_y[k][a] + (r_x[k][a] >>> k);
                    r_z[k+1][a] <= r_z[k][a] - atan_turn(5'(k));
                end else begin
                    r_x[k+1][a] <= r_x[k][a] + (r_y[k][a] >>> k);
                    r_y[k+1][a] <= r_y[k][a] - (r_x[k][a] >>> k);
                    r_z[k+1][a] <= r_z[k][a] + atan_turn(5'(k));
                end
                r_flip[k+1][a] <= r_flip[k][a];
            end
        end
    end

    // Undo the fold and round Q30 down to Q20
    always_comb begin
        for (int a = 0; a < N_AXES; a++) begin
            w_xn[a] = r_flip[N_STEPS][a] ? -r_x[N_STEPS][a] : r_x[N_STEPS][a];
            w_yn[a] = r_flip[N_STEPS][a] ? -r_y[N_STEPS][a] : r_y[N_STEPS][a];
            w_cr[a] = (w_xn[a] + TRIG_RND) >>> TRIG_SH;
            w_sr[a] = (w_yn[a] + TRIG_RND) >>> TRIG_SH;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < N_AXES; a++) begin
            r_trig[a].c <= w_cr[a][TRIG_W-1:0];
            r_trig[a].s <= w_sr[a][TRIG_W-1:0];
        end
    end

    // Advance the valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[N_STEPS-1:0], i_valid};
            r_out_vld <= r_vld[N_STEPS];
        end
    end

    assign o_valid = r_out_vld;
    assign o_trig  = r_trig;

endmodule

@@ hdl/e2r_mat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_mat: rotation matrix products
// Four stages: pair products, split partial products of the triples,
// triple reassembly, and element sums, all exact and ending in Q60.
// ----------------------------------------------------------------------------
module e2r_mat import e2r_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_trig  i_trig [N_AXES],
    output logic   o_valid,
    output t_acc   o_q60 [N_ELEM]
);

    logic signed [TRIG_W-1:0] w_sh, w_ch, w_sa, w_ca, w_sb, w_cb;

    // Stage 1: pair products in Q40
    logic signed [PROD_W-1:0] r1_ch_ca, r1_sh_sb, r1_sh_cb, r1_ca_cb, r1_ca_sb;
    logic signed [PROD_W-1:0] r1_sh_ca, r1_ch_sb, r1_ch_cb, r1_ch_sa, r1_sh_sa;
    logic signed [TRIG_W-1:0] r1_sa, r1_sb, r1_cb;

    // Stage 2: triple partial products, high and low halves
    logic signed [PROD_W-1:0] r2_csc_h, r2_css_h, r2_ssc_h, r2_sss_h;
    logic signed [PL_W-1:0]   r2_csc_l, r2_css_l, r2_ssc_l, r2_sss_l;
    logic signed [PROD_W-1:0] r2_ch_ca, r2_sh_sb, r2_sh_cb, r2_ca_cb, r2_ca_sb;
    logic signed [PROD_W-1:0] r2_sh_ca, r2_ch_sb, r2_ch_cb;
    logic signed [TRIG_W-1:0] r2_sa;

    // Stage 3: triples and pairs in Q60
    t_acc r3_csc, r3_css, r3_ssc, r3_sss;
    t_acc r3_ch_ca, r3_sh_sb, r3_sh_cb, r3_ca_cb, r3_ca_sb;
    t_acc r3_sh_ca, r3_ch_sb, r3_ch_cb, r3_sa;

    // Stage 4: elements
    t_acc r4_q60 [N_ELEM];

    logic [3:0] r_vld;

    always_comb begin
        w_sh = i_trig[AX_HEAD].s;
        w_ch = i_trig[AX_HEAD].c;
        w_sa = i_trig[AX_ATT].s;
        w_ca = i_trig[AX_ATT].c;
        w_sb = i_trig[AX_BANK].s;
        w_cb = i_trig[AX_BANK].c;
    end

    // Form the pair products
    always_ff @(posedge i_clk) begin
        r1_ch_ca <= w_ch * w_ca;
        r1_sh_sb <= w_sh * w_sb;
        r1_sh_cb <= w_sh * w_cb;
        r1_ca_cb <= w_ca * w_cb;
        r1_ca_sb <= w_ca * w_sb;
        r1_sh_ca <= w_sh * w_ca;
        r1_ch_sb <= w_ch * w_sb;
        r1_ch_cb <= w_ch * w_cb;
        r1_ch_sa <= w_ch * w_sa;
        r1_sh_sa <= w_sh * w_sa;
        r1_sa    <= w_sa;
        r1_sb    <= w_sb;
        r1_cb    <= w_cb;
    end

    // Split Q40 pairs ch*sa, sh*sa in halves and multiply by the third factor
    always_ff @(posedge i_clk) begin
        r2_csc_h <= $signed(r1_ch_sa[PROD_W-1:TRIG_W]) * r1_cb;
        r2_css_h <= $signed(r1_ch_sa[PROD_W-1:TRIG_W]) * r1_sb;
        r2_ssc_h <= $signed(r1_sh_sa[PROD_W-1:TRIG_W]) * r1_cb;
        r2_sss_h <= $signed(r1_sh_sa[PROD_W-1:TRIG_W]) * r1_sb;
        r2_csc_l <= $signed({1'b0, r1_ch_sa[TRIG_W-1:0]}) * r1_cb;
        r2_css_l <= $signed({1'b0, r1_ch_sa[TRIG_W-1:0]}) * r1_sb;
        r2_ssc_l <= $signed({1'b0, r1_sh_sa[TRIG_W-1:0]}) * r1_cb;
        r2_sss_l <= $signed({1'b0, r1_sh_sa[TRIG_W-1:0]}) * r1_sb;
        r2_ch_ca <= r1_ch_ca;
        r2_sh_sb <= r1_sh_sb;
        r2_sh_cb <= r1_sh_cb;
        r2_ca_cb <= r1_ca_cb;
        r2_ca_sb <= r1_ca_sb;
        r2_sh_ca <= r1_sh_ca;
        r2_ch_sb <= r1_ch_sb;
        r2_ch_cb <= r1_ch_cb;
        r2_sa    <= r1_sa;
    end

    // Reassemble the triples and lift everything to Q60
    always_ff @(posedge i_clk) begin
        r3_csc   <= (t_acc'(r2_csc_h) <<< TRIG_W) + t_acc'(r2_csc_l);
        r3_css   <= (t_acc'(r2_css_h) <<< TRIG_W) + t_acc'(r2_css_l);
        r3_ssc   <= (t_acc'(r2_ssc_h) <<< TRIG_W) + t_acc'(r2_ssc_l);
        r3_sss   <= (t_acc'(r2_sss_h) <<< TRIG_W) + t_acc'(r2_sss_l);
        r3_ch_ca <= t_acc'(r2_ch_ca) <<< TRIG_Q;
        r3_sh_sb <= t_acc'(r2_sh_sb) <<< TRIG_Q;
        r3_sh_cb <= t_acc'(r2_sh_cb) <<< TRIG_Q;
        r3_ca_cb <= t_acc'(r2_ca_cb) <<< TRIG_Q;
        r3_ca_sb <= t_acc'(r2_ca_sb) <<< TRIG_Q;
        r3_sh_ca <= t_acc'(r2_sh_ca) <<< TRIG_Q;
        r3_ch_sb <= t_acc'(r2_ch_sb) <<< TRIG_Q;
        r3_ch_cb <= t_acc'(r2_ch_cb) <<< TRIG_Q;
        r3_sa    <= t_acc'(r2_sa) <<< PROD_Q;
    end

    // Combine into the nine elements
    always_ff @(posedge i_clk) begin
        r4_q60[E_R0C0] <= r3_ch_ca;
        r4_q60[E_R0C1] <= r3_sh_sb - r3_csc;
        r4_q60[E_R0C2] <= r3_css + r3_sh_cb;
        r4_q60[E_R1C0] <= r3_sa;
        r4_q60[E_R1C1] <= r3_ca_cb;
        r4_q60[E_R1C2] <= -r3_ca_sb;
        r4_q60[E_R2C0] <= -r3_sh_ca;
        r4_q60[E_R2C1] <= r3_ssc + r3_ch_sb;
        r4_q60[E_R2C2] <= r3_ch_cb - r3_sss;
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign o_valid = r_vld[3];
    assign o_q60   = r4_q60;

endmodule

@@ hdl/e2r_sat.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_sat: round and saturate the matrix elements
// Rounds each Q60 element to Q FRAC_BITS, clamps it to plus or minus one
// and keeps the low field bits.
// ----------------------------------------------------------------------------
module e2r_sat import e2r_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  t_acc                          i_q60 [N_ELEM],
    output logic                          o_valid,
    output logic [N_ELEM-1:0][ELEM_W-1:0] o_elem
);

    localparam int   FSH = ACC_Q - FRAC_BITS;
    localparam t_acc RND = t_acc'(1) <<< (FSH - 1);
    localparam t_acc LIM = t_acc'(1) <<< FRAC_BITS;

    t_acc                          w_r [N_ELEM];
    t_acc                          w_c [N_ELEM];
    logic [N_ELEM-1:0][ELEM_W-1:0] r_elem;
    logic                          r_vld;

    // Round to nearest, ties up, then clamp
    always_comb begin
        for (int e = 0; e < N_ELEM; e++) begin
            w_r[e] = (i_q60[e] + RND) >>> FSH;
            if (w_r[e] > LIM) begin
                w_c[e] = LIM;
            end else if (w_r[e] < -LIM) begin
                w_c[e] = -LIM;
            end else begin
                w_c[e] = w_r[e];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < N_ELEM; e++) begin
            r_elem[e] <= w_c[e][ELEM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
    end

    assign o_valid = r_vld;
    assign o_elem  = r_elem;

endmodule

@@ hdl/e2r_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_chk: port-level checks for euler_to_rotation_matrix
// Checks fixed latency between accepted beats and results, reset clearing,
// and, if FRAC_BITS <= ELEM_W - 2, that elements lie within plus or minus one.
// ----------------------------------------------------------------------------
module e2r_chk import e2r_pkg::*; #(
    parameter int LAT       = 23,
    parameter int FRAC_BITS = 14
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input logic [ELEM_W-1:0] o_elem_r0c0,
    input logic [ELEM_W-1:0] o_elem_r0c1,
    input logic [ELEM_W-1:0] o_elem_r0c2,
    input logic [ELEM_W-1:0] o_elem_r1c0,
    input logic [ELEM_W-1:0] o_elem_r1c1,
    input logic [ELEM_W-1:0] o_elem_r1c2,
    input logic [ELEM_W-1:0] o_elem_r2c0,
    input logic [ELEM_W-1:0] o_elem_r2c1,
    input logic [ELEM_W-1:0] o_elem_r2c2
);

    localparam int LIM = 1 << FRAC_BITS;

    function automatic logic in_rng(input logic [ELEM_W-1:0] v);
        return ($signed(v) <= LIM) && ($signed(v) >= -LIM);
    endfunction

    // Every accepted beat yields a result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("accepted beat produced no result at fixed latency");

    // No result without a matching accepted beat
    a_no_ghost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without an accepted beat");

    // Reset drops any result in flight
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // Saturated elements stay within plus or minus one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (FRAC_BITS > ELEM_W - 2) ||
                    (in_rng(o_elem_r0c0) && in_rng(o_elem_r0c1) &&
                     in_rng(o_elem_r0c2) && in_rng(o_elem_r1c0) &&
                     in_rng(o_elem_r1c1) && in_rng(o_elem_r1c2) &&
                     in_rng(o_elem_r2c0) && in_rng(o_elem_r2c1) &&
                     in_rng(o_elem_r2c2)))
        else $error("matrix element outside plus or minus one");

endmodule

bind euler_to_rotation_matrix e2r_chk #(
    .LAT       (LATENCY),
    .FRAC_BITS (FRAC_BITS)
) u_e2r_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_elem_r0c0 (o_elem_r0c0),
    .o_elem_r0c1 (o_elem_r0c1),
    .o_elem_r0c2 (o_elem_r0c2),
    .o_elem_r1c0 (o_elem_r1c0),
    .o_elem_r1c1 (o_elem_r1c1),
    .o_elem_r1c2 (o_elem_r1c2),
    .o_elem_r2c0 (o_elem_r2c0),
    .o_elem_r2c1 (o_elem_r2c1),
    .o_elem_r2c2 (o_elem_r2c2)
);
